// ----- sv/vff_pkg.sv -----
// Shared types, constants and step functions for the vortex force field.
package vff_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int SQ_STEPS  = 33;
	localparam int SQ_PER    = 3;
	localparam int SQ_STG    = SQ_STEPS / SQ_PER;
	localparam int DV_STEPS  = 64;
	localparam int DV_PER    = 4;
	localparam int DV_STG    = DV_STEPS / DV_PER;
	localparam logic [63:0] ATTR_CLAMP = 64'h0001_0000_0000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTRE_X  = 3'd0,
		REG_CENTRE_Y  = 3'd1,
		REG_CENTRE_Z  = 3'd2,
		REG_SWIRL     = 3'd3,
		REG_AXIS      = 3'd4,
		REG_INNER     = 3'd5,
		REG_PULL      = 3'd6,
		REG_ENABLED   = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		AX_X = 2'd0,
		AX_Y = 2'd1,
		AX_Z = 2'd2
	} axis_t;

	// One particle inside the root and divider pipeline.
	typedef struct packed {
		logic             valid;
		logic [2:0][48:0] sw;     // swirl terms, signed
		logic [2:0][31:0] vel;
		logic [2:0]       psgn;   // sign of offset times pull
		logic [2:0][63:0] num;    // dividend, becomes quotient
		logic [2:0][32:0] drem;
		logic [65:0]      rad;    // radicand, consumed two bits a step
		logic [34:0]      srem;
		logic [32:0]      root;
	} pipe_t;

	function automatic pipe_t sqrt_step(pipe_t p);
		pipe_t       n;
		logic [36:0] t;
		logic [36:0] trial;
		n = p;
		t = {p.srem, p.rad[65:64]};
		trial = {2'b00, p.root, 2'b01};
		if (t >= trial) begin
			n.srem = 35'(t - trial);
			n.root = {p.root[31:0], 1'b1};
		end else begin
			n.srem = t[34:0];
			n.root = {p.root[31:0], 1'b0};
		end
		n.rad = {p.rad[63:0], 2'b00};
		return n;
	endfunction

	function automatic pipe_t div_step(pipe_t p);
		pipe_t       n;
		logic [33:0] s;
		logic        qb;
		n = p;
		for (int i = 0; i < 3; i++) begin
			s = {p.drem[i], p.num[i][63]};
			qb = (s >= {1'b0, p.root});
			if (qb) begin
				n.drem[i] = 33'(s - {1'b0, p.root});
			end else begin
				n.drem[i] = s[32:0];
			end
			n.num[i] = {p.num[i][62:0], qb};
		end
		return n;
	endfunction

endpackage

// ----- sv/vff_particle_if.sv -----
// Particle and force channels.
interface vff_particle_if;
	logic        valid;
	logic        ready;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] pos_z;
	logic [31:0] vel_x;
	logic [31:0] vel_y;
	logic [31:0] vel_z;
	modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

interface vff_force_if;
	logic        valid;
	logic        ready;
	logic [31:0] force_x;
	logic [31:0] force_y;
	logic [31:0] force_z;
	logic        on_axis;
	modport source (output valid, force_x, force_y, force_z, on_axis, input ready);
	modport sink (input valid, force_x, force_y, force_z, on_axis, output ready);
endinterface

// ----- sv/vff_root_stage.sv -----
// One square-root pipeline stage: several restoring root steps.
module vff_root_stage import vff_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  pipe_t din,
	output pipe_t dout
);
	logic  vld_s1;
	pipe_t pay_s1;
	pipe_t nxt;

	always_comb begin
		nxt = din;
		for (int k = 0; k < SQ_PER; k++) begin
			nxt = sqrt_step(nxt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s1 <= nxt;
		end
	end

	always_comb begin
		dout = pay_s1;
		dout.valid = vld_s1;
	end
endmodule

// ----- sv/vff_div_stage.sv -----
// One divider pipeline stage: several restoring quotient bits on all three lanes.
module vff_div_stage import vff_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  pipe_t din,
	output pipe_t dout
);
	logic  vld_s1;
	pipe_t pay_s1;
	pipe_t nxt;

	always_comb begin
		nxt = din;
		for (int k = 0; k < DV_PER; k++) begin
			nxt = div_step(nxt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s1 <= nxt;
		end
	end

	always_comb begin
		dout = pay_s1;
		dout.valid = vld_s1;
	end
endmodule

// ----- sv/vortex_force_field.sv -----
// Vortex force field: one particle in, one force out, every cycle unless the
// sink stalls. A particle passes three front stages (offset, plane select,
// multiplies), 11 square-root stages of three root steps each, 16 divider
// stages of four quotient bits each on three parallel lanes, and an output
// register. The whole pipeline advances together whenever the output register
// is empty or its beat is taken, so throughput is one particle per cycle as
// long as the sink keeps up. The user must write configuration only while the
// pipeline holds no particle; the block itself does not enforce this.
module vortex_force_field import vff_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [31:0]          cfg_data,
	vff_particle_if.sink         particle,
	vff_force_if.source          force_out
);
	logic [2:0][31:0] centre_q;
	logic [31:0]      gain_q;
	logic [1:0]       axis_q;
	logic [30:0]      inner_q;
	logic [31:0]      pull_q;
	logic             en_q;

	logic             adv;
	logic             v_s1, v_s2;
	logic [2:0][32:0] d_s1, d_s2;
	logic [2:0][31:0] vel_s1, vel_s2;
	logic [2:0][32:0] so_s2;
	logic [32:0]      ma_s2, mb_s2;

	pipe_t            p3_nxt, p3_s3;
	logic             v_s3;
	pipe_t            sq_pipe [SQ_STG+1];
	pipe_t            dv_pipe [DV_STG+1];

	logic             out_valid_q;
	logic [2:0][31:0] force_q;
	logic             on_axis_q;
	logic [2:0][31:0] force_nxt;

	assign adv = !out_valid_q || force_out.ready;
	assign particle.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_q <= '0;
			gain_q   <= '0;
			axis_q   <= AX_Y;
			inner_q  <= '0;
			pull_q   <= '0;
			en_q     <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_CENTRE_X: centre_q[0] <= cfg_data;
				REG_CENTRE_Y: centre_q[1] <= cfg_data;
				REG_CENTRE_Z: centre_q[2] <= cfg_data;
				REG_SWIRL:    gain_q      <= cfg_data;
				REG_AXIS:     axis_q      <= cfg_data[1:0];
				REG_INNER:    inner_q     <= cfg_data[30:0];
				REG_PULL:     pull_q      <= cfg_data;
				REG_ENABLED:  en_q        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// front control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= particle.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: offset from centre at full width
	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1[0] <= {particle.pos_x[31], particle.pos_x} - {centre_q[0][31], centre_q[0]};
			d_s1[1] <= {particle.pos_y[31], particle.pos_y} - {centre_q[1][31], centre_q[1]};
			d_s1[2] <= {particle.pos_z[31], particle.pos_z} - {centre_q[2][31], centre_q[2]};
			vel_s1  <= {particle.vel_z, particle.vel_y, particle.vel_x};
		end
	end

	// stage 2: rotated operands and in-plane magnitudes
	always_ff @(posedge clk) begin
		if (adv) begin
			d_s2   <= d_s1;
			vel_s2 <= vel_s1;
			case (axis_q)
				AX_X: begin
					so_s2[0] <= '0;
					so_s2[1] <= d_s1[2];
					so_s2[2] <= -d_s1[1];
					ma_s2    <= d_s1[1][32] ? -d_s1[1] : d_s1[1];
					mb_s2    <= d_s1[2][32] ? -d_s1[2] : d_s1[2];
				end
				AX_Y: begin
					so_s2[0] <= -d_s1[2];
					so_s2[1] <= '0;
					so_s2[2] <= d_s1[0];
					ma_s2    <= d_s1[0][32] ? -d_s1[0] : d_s1[0];
					mb_s2    <= d_s1[2][32] ? -d_s1[2] : d_s1[2];
				end
				default: begin
					so_s2[0] <= d_s1[1];
					so_s2[1] <= -d_s1[0];
					so_s2[2] <= '0;
					ma_s2    <= d_s1[0][32] ? -d_s1[0] : d_s1[0];
					mb_s2    <= d_s1[1][32] ? -d_s1[1] : d_s1[1];
				end
			endcase
		end
	end

	// stage 3: swirl products, pull products, radicand
	always_comb begin
		logic signed [64:0] swp;
		logic signed [64:0] pp;
		logic        [64:0] pm;
		p3_nxt = '0;
		for (int i = 0; i < 3; i++) begin
			swp = $signed(gain_q) * $signed(so_s2[i]);
			pp  = $signed(pull_q) * $signed(d_s2[i]);
			pm  = pp[64] ? 65'(-pp) : 65'(pp);
			p3_nxt.sw[i]   = swp[64:16];
			p3_nxt.psgn[i] = pp[64];
			p3_nxt.num[i]  = pm[63:0];
			p3_nxt.vel[i]  = vel_s2[i];
		end
		p3_nxt.rad = 66'(ma_s2) * 66'(ma_s2) + 66'(mb_s2) * 66'(mb_s2);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p3_s3 <= p3_nxt;
		end
	end

	always_comb begin
		sq_pipe[0] = p3_s3;
		sq_pipe[0].valid = v_s3;
	end

	for (genvar g = 0; g < SQ_STG; g++) begin : g_root
		vff_root_stage u_root (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.din    (sq_pipe[g]),
			.dout   (sq_pipe[g+1])
		);
	end

	assign dv_pipe[0] = sq_pipe[SQ_STG];

	for (genvar g = 0; g < DV_STG; g++) begin : g_div
		vff_div_stage u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.din    (dv_pipe[g]),
			.dout   (dv_pipe[g+1])
		);
	end

	// final sum with attraction clamp, damping and saturation
	always_comb begin
		logic        [48:0] qc;
		logic signed [50:0] attr;
		logic signed [51:0] sum;
		logic               damp;
		damp = (dv_pipe[DV_STG].root >= {2'b00, inner_q});
		for (int i = 0; i < 3; i++) begin
			if (dv_pipe[DV_STG].num[i] > ATTR_CLAMP) begin
				qc = ATTR_CLAMP[48:0];
			end else begin
				qc = dv_pipe[DV_STG].num[i][48:0];
			end
			attr = dv_pipe[DV_STG].psgn[i] ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
			sum = 52'($signed(dv_pipe[DV_STG].sw[i]));
			if (dv_pipe[DV_STG].root != '0) begin
				sum = sum - 52'(attr);
			end
			if (damp) begin
				sum = sum - 52'($signed(dv_pipe[DV_STG].vel[i]));
			end
			if (sum > 52'sd2147483647) begin
				force_nxt[i] = 32'h7FFF_FFFF;
			end else if (sum < -52'sd2147483648) begin
				force_nxt[i] = 32'h8000_0000;
			end else begin
				force_nxt[i] = sum[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_pipe[DV_STG].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			force_q   <= en_q ? force_nxt : '0;
			on_axis_q <= en_q && (dv_pipe[DV_STG].root == '0);
		end
	end

	assign force_out.valid   = out_valid_q;
	assign force_out.force_x = force_q[0];
	assign force_out.force_y = force_q[1];
	assign force_out.force_z = force_q[2];
	assign force_out.on_axis = on_axis_q;
endmodule

// ----- sv/vff_checker.sv -----
// Port-level checks for the vortex force field, bound to the top level.
module vff_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] fx,
	input logic [31:0] fy,
	input logic [31:0] fz,
	input logic        on_axis
);
	// hold a stalled beat
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("force beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(fx) && $stable(fy) && $stable(fz) && $stable(on_axis))
		else $error("force beat changed while stalled");

	// input side advances exactly when the output register can move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("particle ready out of step with output register");

	a_reset: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("force beat during reset");
endmodule

bind vortex_force_field vff_checker u_vff_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (particle.ready),
	.out_valid (force_out.valid),
	.out_ready (force_out.ready),
	.fx        (force_out.force_x),
	.fy        (force_out.force_y),
	.fz        (force_out.force_z),
	.on_axis   (force_out.on_axis)
);
